// ----- src/box_blur_5x5_clipped_defines.svh -----
// Assertion helpers shared by the blur block's modules
`ifndef BOX_BLUR_5X5_CLIPPED_DEFINES_SVH
`define BOX_BLUR_5X5_CLIPPED_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define BB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define BB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bb_pkg.sv -----
package bb_pkg;

  localparam int CFG_W = 9;
  localparam int PIX_W = 8;
  localparam int SUM_W = 13;  // 25 * 255 fits
  localparam int CNT_W = 5;   // up to 25 taps

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [2:0] TAP_LAST = 3'd4;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel;
  } bb_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic             frame_last;
  } bb_out_t;

endpackage

// ----- src/box_blur_5x5_clipped.sv -----
// A result leaves once the pixel two rows and two pixels later is taken; the back end
//   then walks its 25 taps over the single line-store read port and runs a 13-step divide.
// One non-emitting pixel is taken per cycle while the command queue has room; the back end
//   takes no new command until the result in hand is pushed.
// Reset: synchronous active-low; clears positions, queues and sequencer, sizes to 256.
module box_blur_5x5_clipped
  import bb_pkg::*;
#(
  parameter int MAX_SIDE = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  bb_in_t           in_data,
  output logic             in_full,
  output logic             out_empty,
  input  logic             out_pop,
  output bb_out_t          out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int RW    = $clog2(MAX_SIDE + 1);
  localparam int AW    = $clog2(4 * MAX_SIDE + 8);
  localparam int CMD_W = 3 + PIX_W + 2 * AW + 2 * RW;
  localparam int OUT_W = $bits(bb_out_t);

  logic             q_push, q_full, q_pop, q_empty;
  logic [CMD_W-1:0] q_wdata, q_rdata;
  logic [RW-1:0]    w, h;
  logic             o_push, o_full;
  bb_out_t          o_data;
  logic [OUT_W-1:0] o_rdata;

  bb_front #(.MAX_SIDE(MAX_SIDE), .RW(RW), .AW(AW), .CMD_W(CMD_W)) u_front (
    .clk, .rst_n, .in_push, .in_data, .in_full, .cfg_we, .cfg_index, .cfg_wdata,
    .q_push, .q_data(q_wdata), .q_full, .w, .h
  );

  bb_fifo #(.WIDTH(CMD_W), .DEPTH(4)) u_cmd_q (
    .clk, .rst_n, .push(q_push), .push_data(q_wdata), .full(q_full),
    .pop(q_pop), .pop_data(q_rdata), .empty(q_empty)
  );

  bb_back #(.MAX_SIDE(MAX_SIDE), .RW(RW), .AW(AW), .CMD_W(CMD_W)) u_back (
    .clk, .rst_n, .q_empty, .q_pop, .q_data(q_rdata), .w, .h,
    .o_push, .o_data, .o_full
  );

  bb_fifo #(.WIDTH(OUT_W), .DEPTH(2)) u_out_q (
    .clk, .rst_n, .push(o_push), .push_data(o_data), .full(o_full),
    .pop(out_pop), .pop_data(o_rdata), .empty(out_empty)
  );

  assign out_data = bb_out_t'(o_rdata);

endmodule

// ----- src/bb_fifo.sv -----
`include "box_blur_5x5_clipped_defines.svh"

module bb_fifo
  import bb_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // store each beat at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `BB_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH), "fifo overfilled")
  `BB_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full, "push into full fifo")
  `BB_ASSERT_NXT(a_pop_drain, clk, rst_n, do_pop && !do_push && cnt_r == CW'(1), empty, "fifo not empty after last beat")

endmodule

// ----- src/bb_front.sv -----
module bb_front
  import bb_pkg::*;
#(
  parameter int MAX_SIDE = 256,
  parameter int RW       = 9,
  parameter int AW       = 11,
  parameter int CMD_W    = 51
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  bb_in_t           in_data,
  output logic             in_full,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output logic             q_push,
  output logic [CMD_W-1:0] q_data,
  input  logic             q_full,
  output logic [RW-1:0]    w,
  output logic [RW-1:0]    h
);

  localparam int DEPTH = 4 * MAX_SIDE + 8;
  localparam int LW    = $clog2(2 * MAX_SIDE + 4);
  localparam int CW    = ((RW > CFG_W) ? RW : CFG_W) + 1;

  logic [CFG_W-1:0] cfg_w_r, cfg_h_r;
  logic [RW-1:0]    in_row_r, in_col_r, out_row_r, out_col_r;
  logic [AW-1:0]    in_addr_r, out_addr_r;
  logic [LW-1:0]    lag_r;

  logic          accept, pix_ok, emit_pix, emit_fl, emit, last;
  logic [LW-1:0] thr, lag_inc;
  logic [AW-1:0] thr_a, start_addr;
  logic [CW-1:0] cw_ext, ch_ext;

  // clamp the frame size to 1..MAX_SIDE
  always_comb begin
    cw_ext = CW'(cfg_w_r);
    ch_ext = CW'(cfg_h_r);
    if (cw_ext == '0)                w = RW'(1);
    else if (cw_ext > CW'(MAX_SIDE)) w = RW'(MAX_SIDE);
    else                             w = RW'(cw_ext);
    if (ch_ext == '0)                h = RW'(1);
    else if (ch_ext > CW'(MAX_SIDE)) h = RW'(MAX_SIDE);
    else                             h = RW'(ch_ext);
  end

  // classify the incoming beat
  assign in_full  = q_full;
  assign accept   = in_push && !q_full;
  assign thr      = LW'({w, 1'b0}) + LW'(2);
  assign lag_inc  = lag_r + 1'b1;
  assign pix_ok   = (in_data.op == OP_PIXEL) && (in_row_r < h);
  assign emit_pix = pix_ok && (lag_inc > thr);
  assign emit_fl  = (in_data.op == OP_FLUSH) && (in_row_r >= h) && (lag_r != '0);
  assign emit     = accept && (emit_pix || emit_fl);
  assign last     = (out_row_r == h - 1'b1) && (out_col_r == w - 1'b1);

  // window origin: two rows and two pixels before the result position
  assign thr_a      = AW'(thr);
  assign start_addr = (out_addr_r >= thr_a) ? out_addr_r - thr_a
                                            : out_addr_r + AW'(DEPTH) - thr_a;

  assign q_push = accept && (pix_ok || emit);
  assign q_data = {pix_ok, emit, last, in_data.pixel, in_addr_r, start_addr,
                   out_row_r, out_col_r};

  // track raster positions; restart on config or after the last result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r    <= CFG_W'(256);
      cfg_h_r    <= CFG_W'(256);
      in_row_r   <= '0;
      in_col_r   <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      in_addr_r  <= '0;
      out_addr_r <= '0;
      lag_r      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) cfg_w_r <= cfg_wdata;
      else                        cfg_h_r <= cfg_wdata;
      in_row_r   <= '0;
      in_col_r   <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      in_addr_r  <= '0;
      out_addr_r <= '0;
      lag_r      <= '0;
    end else if (accept) begin
      if (pix_ok) begin
        in_addr_r <= (in_addr_r == AW'(DEPTH - 1)) ? '0 : in_addr_r + 1'b1;
        if (in_col_r == w - 1'b1) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
        lag_r <= emit ? lag_r : lag_inc;
      end else if (emit) begin
        lag_r <= lag_r - 1'b1;
      end
      if (emit) begin
        out_addr_r <= (out_addr_r == AW'(DEPTH - 1)) ? '0 : out_addr_r + 1'b1;
        if (out_col_r == w - 1'b1) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + 1'b1;
        end else begin
          out_col_r <= out_col_r + 1'b1;
        end
        if (last) begin
          in_row_r   <= '0;
          in_col_r   <= '0;
          out_row_r  <= '0;
          out_col_r  <= '0;
          in_addr_r  <= '0;
          out_addr_r <= '0;
          lag_r      <= '0;
        end
      end
    end
  end

endmodule

// ----- src/bb_back.sv -----
`include "box_blur_5x5_clipped_defines.svh"

module bb_back
  import bb_pkg::*;
#(
  parameter int MAX_SIDE = 256,
  parameter int RW       = 9,
  parameter int AW       = 11,
  parameter int CMD_W    = 51
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic [CMD_W-1:0] q_data,
  input  logic [RW-1:0]    w,
  input  logic [RW-1:0]    h,
  output logic             o_push,
  output bb_out_t          o_data,
  input  logic             o_full
);

  localparam int DEPTH = 4 * MAX_SIDE + 8;
  localparam int IW    = $clog2(SUM_W);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TAP   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;

  // unpack the command
  logic             c_wr, c_emit, c_last;
  logic [PIX_W-1:0] c_pixel;
  logic [AW-1:0]    c_wr_addr, c_start;
  logic [RW-1:0]    c_row, c_col;
  assign {c_wr, c_emit, c_last, c_pixel, c_wr_addr, c_start, c_row, c_col} = q_data;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    tap_addr_r;
  logic [2:0]       dy_r, dx_r;
  logic [RW-1:0]    row_r, col_r;
  logic             last_r, vld_d_r;
  logic [SUM_W-1:0] sum_r, quo_r;
  logic [CNT_W-1:0] cnt_r, rem_r;
  logic [IW-1:0]    div_i_r;

  logic             mem_we, tap_in;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] cnt_add;
  logic signed [RW+1:0] rs, cs;
  logic signed [AW+1:0] step, nxt_s;
  logic [AW-1:0]    tap_nxt;
  logic [CNT_W:0]   rem_sh;
  logic             qbit;
  logic [CNT_W-1:0] rem_new;

  assign q_pop  = (state_r == S_IDLE) && !q_empty;
  assign mem_we = q_pop && c_wr;

  // line stores: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[c_wr_addr] <= c_pixel;
    end
    rd_data_r <= mem[tap_addr_r];
  end

  // tap position inside the frame
  always_comb begin
    rs     = $signed({2'b00, row_r}) + $signed((RW+2)'(dy_r)) - $signed((RW+2)'(2));
    cs     = $signed({2'b00, col_r}) + $signed((RW+2)'(dx_r)) - $signed((RW+2)'(2));
    tap_in = !rs[RW+1] && (rs[RW:0] < {1'b0, h}) &&
             !cs[RW+1] && (cs[RW:0] < {1'b0, w});
  end

  // next tap address around the ring
  always_comb begin
    step = (dx_r == TAP_LAST) ? $signed({2'b00, AW'(w)}) - $signed((AW+2)'(4))
                              : $signed((AW+2)'(1));
    nxt_s = $signed({2'b00, tap_addr_r}) + step;
    if (nxt_s < 0) begin
      nxt_s = nxt_s + $signed((AW+2)'(DEPTH));
    end else if (nxt_s >= $signed((AW+2)'(DEPTH))) begin
      nxt_s = nxt_s - $signed((AW+2)'(DEPTH));
    end
    tap_nxt = AW'(nxt_s);
  end

  // accumulate the tap read in the previous cycle
  assign sum_add = vld_d_r ? sum_r + SUM_W'(rd_data_r) : sum_r;
  assign cnt_add = vld_d_r ? cnt_r + 1'b1 : cnt_r;

  // one restoring divide step
  always_comb begin
    rem_sh  = {rem_r, quo_r[SUM_W-1]};
    qbit    = (rem_sh >= {1'b0, cnt_r});
    rem_new = qbit ? CNT_W'(rem_sh - {1'b0, cnt_r}) : CNT_W'(rem_sh);
  end

  assign o_push = (state_r == S_PUSH) && !o_full;
  assign o_data = '{blurred: quo_r[PIX_W-1:0], frame_last: last_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (q_pop && c_emit) state_nxt = S_TAP;
      S_TAP:   if (dy_r == TAP_LAST && dx_r == TAP_LAST) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_DIV;
      S_DIV:   if (div_i_r == IW'(SUM_W - 1)) state_nxt = S_PUSH;
      S_PUSH:  if (!o_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        tap_addr_r <= c_start;
        row_r      <= c_row;
        col_r      <= c_col;
        last_r     <= c_last;
        dy_r       <= '0;
        dx_r       <= '0;
        sum_r      <= '0;
        cnt_r      <= '0;
        vld_d_r    <= 1'b0;
      end
      S_TAP: begin
        sum_r      <= sum_add;
        cnt_r      <= cnt_add;
        vld_d_r    <= tap_in;
        tap_addr_r <= tap_nxt;
        if (dx_r == TAP_LAST) begin
          dx_r <= '0;
          dy_r <= dy_r + 1'b1;
        end else begin
          dx_r <= dx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        cnt_r   <= cnt_add;
        quo_r   <= sum_add;
        rem_r   <= '0;
        div_i_r <= '0;
      end
      S_DIV: begin
        quo_r   <= {quo_r[SUM_W-2:0], qbit};
        rem_r   <= rem_new;
        div_i_r <= div_i_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  `BB_ASSERT_IMP(a_div_nonzero, clk, rst_n, state_r == S_DIV, cnt_r != '0, "zero tap count")
  `BB_ASSERT_IMP(a_tap_range, clk, rst_n, state_r == S_TAP, dy_r <= TAP_LAST && dx_r <= TAP_LAST, "tap index out of window")
  `BB_ASSERT_NXT(a_push_done, clk, rst_n, o_push, state_r == S_IDLE, "result not retired")

endmodule

// ----- bench/tb_box_blur_5x5_clipped.sv -----
module tb_box_blur_5x5_clipped;
  timeunit 1ns;
  timeprecision 1ps;
  import bb_pkg::*;

  localparam int SIDE_MAX = 256;
  localparam int RING_LEN = 4 * SIDE_MAX + 8;

  // Blur predictor: mirrors the pixel history and positions, queues expected beats
  class blur_predictor;
    logic [PIX_W-1:0] history[RING_LEN];
    int width_reg, height_reg;
    int in_row, in_col, out_row, out_col, wr_addr, backlog;
    bb_out_t expected_q[$];
    int errors;

    function new();
      foreach (history[i]) history[i] = '0;
      width_reg = SIDE_MAX;
      height_reg = SIDE_MAX;
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      wr_addr = 0; backlog = 0;
    endfunction

    function int clamp_side(int v);
      if (v < 1) return 1;
      if (v > SIDE_MAX) return SIDE_MAX;
      return v;
    endfunction

    // Any register write aborts the frame in progress
    function void write_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == REG_WIDTH) width_reg = int'(val);
      else height_reg = int'(val);
      restart();
    endfunction

    // Average the in-frame neighborhood of the next output position
    function void emit_mean(int w, int h);
      int base, sum, cnt, r, c, a;
      bb_out_t res;
      base = (wr_addr + RING_LEN - backlog) % RING_LEN;
      sum = 0;
      cnt = 0;
      for (int dy = -2; dy <= 2; dy++) begin
        r = out_row + dy;
        if (r < 0 || r >= h) continue;
        for (int dx = -2; dx <= 2; dx++) begin
          c = out_col + dx;
          if (c < 0 || c >= w) continue;
          a = (base + RING_LEN + dy * w + dx) % RING_LEN;
          sum += history[a];
          cnt++;
        end
      end
      if (cnt == 0) cnt = 1;
      res.blurred = PIX_W'(sum / cnt);
      res.frame_last = (out_row == h - 1) && (out_col == w - 1);
      expected_q.push_back(res);
      backlog--;
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      if (res.frame_last) restart();
    endfunction

    function void take_beat(bb_in_t b);
      int w, h;
      w = clamp_side(width_reg);
      h = clamp_side(height_reg);
      if (b.op == OP_PIXEL) begin
        if (in_row >= h) return;
        history[wr_addr] = b.pixel;
        wr_addr = (wr_addr + 1) % RING_LEN;
        backlog++;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
        if (backlog > 2 * w + 2) emit_mean(w, h);
      end else if (in_row >= h && backlog > 0) begin
        emit_mean(w, h);
      end
    endfunction

    function void check_beat(bb_out_t got);
      bb_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result blurred=%0d last=%0b", $time,
                 got.blurred, got.frame_last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.blurred !== want.blurred) begin
        $display("%0t: blurred mismatch expected %0d actual %0d", $time,
                 want.blurred, got.blurred);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $display("%0t: frame_last mismatch expected %0b actual %0b", $time,
                 want.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_push, in_full, out_empty, out_pop;
  bb_in_t in_data;
  bb_out_t out_data;
  logic cfg_we, cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  blur_predictor pred = new();
  bit calm;
  int hold_left;
  int beats_sent;

  box_blur_5x5_clipped DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Sample every accepted beat, register write and popped result at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) pred.write_reg(cfg_index, cfg_wdata);
      if (in_push && !in_full) pred.take_beat(in_data);
      if (out_pop && !out_empty) pred.check_beat(out_data);
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  initial begin
    #10ms;
    $display("FAIL box_blur_5x5_clipped");
    $finish;
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Offer one beat and hold it until the block takes it
  task automatic send_beat(logic op, logic [PIX_W-1:0] pix);
    while (!calm && $urandom_range(99) < 34) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{op: op, pixel: pix};
    do @(posedge clk); while (in_full);
    beats_sent++;
    @(negedge clk);
  endtask

  // Wait until every expected beat is back and the back end has settled
  task automatic drain();
    in_push <= 1'b0;
    while (pred.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Set the frame size and stream pixels; a whole frame is then flushed, a partial one is aborted later
  task automatic run_frame(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv, bit whole, bit noisy);
    int w, h, n;
    write_reg(REG_WIDTH, wv);
    write_reg(REG_HEIGHT, hv);
    w = pred.clamp_side(wv);
    h = pred.clamp_side(hv);
    n = whole ? w * h : $urandom_range(w * h - 1);
    for (int i = 0; i < n; i++) begin
      // early flush is dropped
      if (noisy && i == n - 1) send_beat(OP_FLUSH, rand_pixel());
      send_beat(OP_PIXEL, rand_pixel());
    end
    if (whole) begin
      // a pixel past the frame end is dropped while results remain
      if (noisy) send_beat(OP_PIXEL, rand_pixel());
      for (int i = 0; i < 2 * w + 3; i++) send_beat(OP_FLUSH, rand_pixel());
    end
    in_push <= 1'b0;
  endtask

  initial begin
    int frames;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_wdata = '0;
    calm = 1'b0;
    hold_left = 0;
    beats_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero sizes act as one, tiny frames, and an aborted frame
    run_frame(9'd0, 9'd0, 1'b1, 1'b1);
    run_frame(9'd2, 9'd1, 1'b1, 1'b0);
    run_frame(9'd3, 9'd3, 1'b1, 1'b1);
    run_frame(9'd4, 9'd2, 1'b0, 1'b0);
    run_frame(9'd1, 9'd5, 1'b1, 1'b0);

    // Random frames, mostly small, a few at the widest setting
    frames = 0;
    while (beats_sent < 1250) begin
      calm = (frames >= 1 && frames < 5);
      if (frames == 6) begin
        // empty the block first so the hold-off fills it with this frame
        drain();
        fork
          run_frame(9'd6, 9'd6, 1'b1, 1'b0);
          hold_left = 3000;
        join
      end else if (frames % 18 == 9) begin
        run_frame(($urandom_range(1)) ? 9'd511 : 9'd256, 9'($urandom_range(1, 2)),
                  1'b1, 1'b0);
      end else if (frames % 18 == 14) begin
        run_frame(9'($urandom_range(1, 2)), 9'd511, 1'b0, 1'b0);
      end else begin
        run_frame(9'($urandom_range(1, 12)), 9'($urandom_range(1, 8)),
                  $urandom_range(99) < 85, $urandom_range(99) < 20);
      end
      frames++;
    end
    calm = 1'b0;

    while (pred.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (pred.errors == 0) begin
      $display("PASS box_blur_5x5_clipped");
    end else begin
      $display("FAIL box_blur_5x5_clipped");
    end
    $finish;
  end

endmodule
